FILE: hw/rtl/remote_stick_poll_handshake_defines.svh
// Assertion macros shared by the link poller RTL.
`ifndef REMOTE_STICK_POLL_HANDSHAKE_DEFINES_SVH
`define REMOTE_STICK_POLL_HANDSHAKE_DEFINES_SVH

// Check a condition in the same cycle as its trigger.
`define RSPH_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition in the cycle after its trigger.
`define RSPH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/rsph_pkg.sv
`default_nettype none

package rsph_pkg;

    // Queue depth between the parts and at the result side
    localparam int QUEUE_DEPTH = 2;

    // Link bytes
    localparam logic [7:0] FRAME_MARK = 8'hFF;
    localparam logic [7:0] REQ_LEFT   = 8'hBB;
    localparam logic [7:0] REQ_RIGHT  = 8'hCC;

    // Reset values
    localparam logic [15:0] LIMIT_RESET   = 16'd500;
    localparam logic [7:0]  NEUTRAL_RESET = 8'd127;
    localparam logic [7:0]  STICK_RESET   = 8'd126;

    // Index of the closing frame mark, after the three payload bytes
    localparam logic [1:0] PAYLOAD_LAST = 2'd3;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_NEUTRAL = 1'b1;

    // Phase codes as seen on the result port
    localparam logic [1:0] LINK_IDLE  = 2'd0;
    localparam logic [1:0] LINK_LEFT  = 2'd1;
    localparam logic [1:0] LINK_RIGHT = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_LEFT  = 3'b010,
        PH_RIGHT = 3'b100
    } t_phase;

    typedef enum logic [2:0] {
        EV_NONE  = 3'b001,
        EV_TICK  = 3'b010,
        EV_FRAME = 3'b100
    } t_evt_kind;

    // Classified item handed from the deframer to the link controller
    typedef struct packed {
        t_evt_kind  kind;
        logic [7:0] tag;
        logic [7:0] y;
        logic [7:0] x;
    } t_evt;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic [7:0] left_y;
        logic [7:0] left_x;
        logic [7:0] right_y;
        logic [7:0] right_x;
        logic [1:0] link_phase;
        logic       timed_out;
        logic       frame_done;
    } t_res;

    localparam int EVT_W = $bits(t_evt);
    localparam int RES_W = $bits(t_res);

    function automatic logic [1:0] phase_code(input t_phase ph);
        logic [1:0] code;
        case (ph)
            PH_LEFT:  code = LINK_LEFT;
            PH_RIGHT: code = LINK_RIGHT;
            default:  code = LINK_IDLE;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/rsph_fifo.sv
`default_nettype none

module rsph_fifo #(
    parameter int Width = 1,
    parameter int Depth = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [Width-1:0] i_din,
    output logic             o_full,
    input  logic             i_pop,
    output logic [Width-1:0] o_dout,
    output logic             o_empty
);

    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CW = $clog2(Depth + 1);

    logic [Width-1:0] r_mem [Depth];
    logic [AW-1:0]    r_wr, n_wr;
    logic [AW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             w_push, w_pop;

    assign o_full  = (r_cnt == CW'(Depth));
    assign o_empty = (r_cnt == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_dout  = r_mem[r_rd];

    // Advance pointers with wrap, track fill level
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wr = (r_wr == AW'(Depth - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_pop) begin
            n_rd = (r_rd == AW'(Depth - 1)) ? '0 : r_rd + 1'b1;
        end
        case ({w_push, w_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Store the incoming beat
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_din;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/rsph_front.sv
`default_nettype none

module rsph_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic          i_op,
    input  logic [7:0]    i_rx_byte,
    output rsph_pkg::t_evt o_evt
);

    import rsph_pkg::*;

    logic       r_started, n_started;
    logic [1:0] r_idx, n_idx;
    logic [7:0] r_pay [3];
    logic       w_store;

    // Classify the beat and step the deframer
    always_comb begin
        n_started  = r_started;
        n_idx      = r_idx;
        w_store    = 1'b0;
        o_evt.kind = EV_NONE;
        o_evt.tag  = r_pay[0];
        o_evt.y    = r_pay[1];
        o_evt.x    = r_pay[2];
        if (i_op) begin
            o_evt.kind = EV_TICK;
        end else if (!r_started) begin
            n_started = (i_rx_byte == FRAME_MARK);
            n_idx     = '0;
        end else if (r_idx != PAYLOAD_LAST) begin
            w_store = 1'b1;
            n_idx   = r_idx + 1'b1;
        end else if (i_rx_byte == FRAME_MARK) begin
            n_started  = 1'b0;
            n_idx      = '0;
            o_evt.kind = EV_FRAME;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_idx     <= '0;
        end else if (i_accept) begin
            r_started <= n_started;
            r_idx     <= n_idx;
        end
    end

    // Capture payload bytes
    always_ff @(posedge i_clk) begin
        if (i_accept && w_store) begin
            r_pay[r_idx] <= i_rx_byte;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/rsph_back.sv
`default_nettype none

module rsph_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rsph_pkg::t_cfg_wr i_cfg,
    input  logic              i_evt_valid,
    input  rsph_pkg::t_evt    i_evt,
    output logic              o_evt_pop,
    input  logic              i_res_full,
    output logic              o_res_push,
    output rsph_pkg::t_res    o_res
);

    import rsph_pkg::*;

    logic [15:0] r_limit;
    logic [7:0]  r_neutral;
    t_phase      r_phase, n_phase, w_ph_tick;
    logic [15:0] r_lcnt, n_lcnt;
    logic [15:0] r_rcnt, n_rcnt;
    logic [7:0]  r_stick [4];
    logic [7:0]  n_stick [4];
    logic        w_txv, w_to, w_fd;
    logic [7:0]  w_txb;

    assign o_evt_pop  = i_evt_valid && !i_res_full;
    assign o_res_push = o_evt_pop;

    // Work out the next link state for the event at the head
    always_comb begin
        n_phase   = r_phase;
        n_lcnt    = r_lcnt;
        n_rcnt    = r_rcnt;
        n_stick   = r_stick;
        w_ph_tick = r_phase;
        w_txv     = 1'b0;
        w_txb     = '0;
        w_to      = 1'b0;
        w_fd      = 1'b0;
        case (i_evt.kind)
            EV_TICK: begin
                // Leave idle with a left request
                if (r_phase == PH_IDLE) begin
                    w_ph_tick = PH_LEFT;
                    w_txv     = 1'b1;
                    w_txb     = REQ_LEFT;
                end
                // Count waiting time for the phase being waited in
                case (w_ph_tick)
                    PH_LEFT: begin
                        n_lcnt = (r_lcnt == 16'hFFFF) ? r_lcnt : r_lcnt + 16'd1;
                        n_rcnt = '0;
                    end
                    PH_RIGHT: begin
                        n_rcnt = (r_rcnt == 16'hFFFF) ? r_rcnt : r_rcnt + 16'd1;
                        n_lcnt = '0;
                    end
                    default: begin
                        n_lcnt = '0;
                        n_rcnt = '0;
                    end
                endcase
                n_phase = w_ph_tick;
                // Drop the link when the wait limit is reached
                if (n_lcnt >= r_limit || n_rcnt >= r_limit) begin
                    for (int k = 0; k < 4; k++) begin
                        n_stick[k] = r_neutral;
                    end
                    n_phase = PH_IDLE;
                    n_lcnt  = '0;
                    n_rcnt  = '0;
                    w_to    = 1'b1;
                end
            end
            EV_FRAME: begin
                w_fd = 1'b1;
                if (i_evt.tag == REQ_LEFT) begin
                    if (r_phase == PH_LEFT) begin
                        n_stick[0] = i_evt.y;
                        n_stick[1] = i_evt.x;
                        n_phase    = PH_RIGHT;
                        w_txv      = 1'b1;
                        w_txb      = REQ_RIGHT;
                    end
                end else if (i_evt.tag == REQ_RIGHT) begin
                    if (r_phase == PH_RIGHT) begin
                        n_stick[2] = i_evt.y;
                        n_stick[3] = i_evt.x;
                        n_phase    = PH_IDLE;
                    end
                end else begin
                    // Unknown tag: force neutral and idle
                    for (int k = 0; k < 4; k++) begin
                        n_stick[k] = r_neutral;
                    end
                    n_phase = PH_IDLE;
                end
            end
            default: ;
        endcase
    end

    // Build the result beat from the state after this event
    always_comb begin
        o_res.tx_valid   = w_txv;
        o_res.tx_byte    = w_txb;
        o_res.left_y     = n_stick[0];
        o_res.left_x     = n_stick[1];
        o_res.right_y    = n_stick[2];
        o_res.right_x    = n_stick[3];
        o_res.link_phase = phase_code(n_phase);
        o_res.timed_out  = w_to;
        o_res.frame_done = w_fd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit   <= LIMIT_RESET;
            r_neutral <= NEUTRAL_RESET;
            r_phase   <= PH_IDLE;
            r_lcnt    <= '0;
            r_rcnt    <= '0;
            for (int k = 0; k < 4; k++) begin
                r_stick[k] <= STICK_RESET;
            end
        end else begin
            // Take configuration writes
            if (i_cfg.we) begin
                case (i_cfg.idx)
                    REG_TIMEOUT: r_limit   <= i_cfg.data;
                    REG_NEUTRAL: r_neutral <= i_cfg.data[7:0];
                    default: ;
                endcase
            end
            // Advance the link state on each popped event
            if (o_evt_pop) begin
                r_phase <= n_phase;
                r_lcnt  <= n_lcnt;
                r_rcnt  <= n_rcnt;
                r_stick <= n_stick;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/remote_stick_poll_handshake.sv
// A beat is stored in the input queue, then its result in the result queue feeding the result ports.
// Throughput: one beat per cycle while not full; the link controller retires one event per cycle
// while the result queue has room. Input and result queues decouple the sides, so a stalled pop does
// not stall push until the queues fill.
// Reset (synchronous, active low): queues empty, idle phase, counters cleared,
// sticks 126, limit 500, neutral 127; no clearing pass.
`default_nettype none

`include "remote_stick_poll_handshake_defines.svh"

module remote_stick_poll_handshake #(
    parameter int QueueDepth = rsph_pkg::QUEUE_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic                             i_op,
    input  logic [7:0]                       i_rx_byte,
    output logic                             empty,
    input  logic                             pop,
    output logic                             o_tx_valid,
    output logic [7:0]                       o_tx_byte,
    output logic [7:0]                       o_left_y,
    output logic [7:0]                       o_left_x,
    output logic [7:0]                       o_right_y,
    output logic [7:0]                       o_right_x,
    output logic [1:0]                       o_link_phase,
    output logic                             o_timed_out,
    output logic                             o_frame_done,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [rsph_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rsph_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    import rsph_pkg::*;

    logic             w_mid_full, w_mid_empty, w_accept;
    logic             w_evt_pop, w_res_push, w_out_full;
    t_evt             w_evt_in, w_evt_out;
    logic [EVT_W-1:0] w_mid_dout;
    t_res             w_res_in, w_res_out;
    logic [RES_W-1:0] w_out_dout;
    t_cfg_wr          w_cfg;

    assign full        = w_mid_full;
    assign w_accept    = push && !w_mid_full;
    assign o_cfg_ready = 1'b1;

    // Pack the configuration beat
    assign w_cfg.we   = i_cfg_valid && o_cfg_ready;
    assign w_cfg.idx  = i_cfg_index;
    assign w_cfg.data = i_cfg_data;

    rsph_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_op      (i_op),
        .i_rx_byte (i_rx_byte),
        .o_evt     (w_evt_in)
    );

    rsph_fifo #(
        .Width (EVT_W),
        .Depth (QueueDepth)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_din   (w_evt_in),
        .o_full  (w_mid_full),
        .i_pop   (w_evt_pop),
        .o_dout  (w_mid_dout),
        .o_empty (w_mid_empty)
    );

    assign w_evt_out = t_evt'(w_mid_dout);

    rsph_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_evt_valid (!w_mid_empty),
        .i_evt       (w_evt_out),
        .o_evt_pop   (w_evt_pop),
        .i_res_full  (w_out_full),
        .o_res_push  (w_res_push),
        .o_res       (w_res_in)
    );

    rsph_fifo #(
        .Width (RES_W),
        .Depth (QueueDepth)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_din   (w_res_in),
        .o_full  (w_out_full),
        .i_pop   (pop),
        .o_dout  (w_out_dout),
        .o_empty (empty)
    );

    // Unpack the head result
    assign w_res_out    = t_res'(w_out_dout);
    assign o_tx_valid   = w_res_out.tx_valid;
    assign o_tx_byte    = w_res_out.tx_byte;
    assign o_left_y     = w_res_out.left_y;
    assign o_left_x     = w_res_out.left_x;
    assign o_right_y    = w_res_out.right_y;
    assign o_right_x    = w_res_out.right_x;
    assign o_link_phase = w_res_out.link_phase;
    assign o_timed_out  = w_res_out.timed_out;
    assign o_frame_done = w_res_out.frame_done;

    // Checks
    `RSPH_ASSERT_SAME(a_tx_code, !empty && o_tx_valid, o_tx_byte == REQ_LEFT || o_tx_byte == REQ_RIGHT, "tx beat with unknown request byte")
    `RSPH_ASSERT_SAME(a_phase_code, !empty, o_link_phase != 2'd3, "result carries phase code 3")
    `RSPH_ASSERT_SAME(a_timeout_idle, !empty && o_timed_out, o_link_phase == LINK_IDLE && !o_frame_done, "timeout beat not idle or also closes a frame")
    `RSPH_ASSERT_NEXT(a_res_lands, w_res_push, !empty, "result pushed but result queue empty next cycle")

endmodule

`default_nettype wire
